// ===== rtl/assert_macros.svh =====
// Concurrent assertion helpers, removed for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SMM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

`define SMM_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition");

`else

`define SMM_ASSERT(lbl, clk, rstn, prop)

`define SMM_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// ===== rtl/smm_pkg.sv =====
`timescale 1ns / 1ps

package smm_pkg;

    localparam int SMM_DIM    = 64;
    localparam int SMM_QDEPTH = 4;

    localparam int IDX_W  = 6;
    localparam int DATA_W = 16;
    localparam int PROD_W = 32;
    localparam int SUM_W  = 40;

    typedef enum logic [1:0] {
        CMD_LOAD_A  = 2'd0,
        CMD_LOAD_B  = 2'd1,
        CMD_COMPUTE = 2'd2
    } cmd_t;

    typedef struct packed {
        cmd_t                      cmd;
        logic [IDX_W-1:0]          row;
        logic signed [DATA_W-1:0]  value;
    } smm_cmd_t;

endpackage

// ===== rtl/smm_ram.sv =====
`timescale 1ns / 1ps

module smm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/smm_front.sv =====
`timescale 1ns / 1ps

module smm_front
    import smm_pkg::*;
#(
    parameter int DIM = SMM_DIM
) (
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,   // row[5:0], col[11:6], value[27:12]
    input  logic [1:0]                    s_axis_tuser,   // cmd[1:0]
    input  logic                          q_full,
    output logic                          push,
    output smm_cmd_t                      push_cmd,
    output logic [$clog2(DIM*DIM)-1:0]    push_addr
);

    localparam int ADDR_W = $clog2(DIM*DIM);

    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic              row_ok;
    logic              col_ok;
    logic              keep;

    assign row    = s_axis_tdata[5:0];
    assign col    = s_axis_tdata[11:6];
    assign row_ok = 32'(row) < DIM;
    assign col_ok = 32'(col) < DIM;

    assign s_axis_tready = !q_full;

    // drop unused codes and out-of-range indexes here
    always_comb
    begin
        keep = 1'b0;
        unique case (s_axis_tuser) inside
            CMD_LOAD_A, CMD_LOAD_B: keep = row_ok && col_ok;
            CMD_COMPUTE:            keep = row_ok;
            default:                keep = 1'b0;
        endcase
    end

    assign push           = s_axis_tvalid && !q_full && keep;
    assign push_cmd.cmd   = cmd_t'(s_axis_tuser);
    assign push_cmd.row   = row;
    assign push_cmd.value = s_axis_tdata[27:12];
    // element address for loads, row base for compute
    assign push_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(DIM))
                     + ((s_axis_tuser == CMD_COMPUTE) ? '0 : ADDR_W'(col));

endmodule

// ===== rtl/smm_queue.sv =====
`timescale 1ns / 1ps

module smm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== rtl/smm_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smm_back
    import smm_pkg::*;
#(
    parameter int DIM = SMM_DIM
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  smm_cmd_t                    q_cmd,
    input  logic [$clog2(DIM*DIM)-1:0]  q_addr,
    output logic                        pop,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [55:0]                 m_axis_tdata,  // out_row[5:0], out_col[11:6], sum[51:12]
    output logic                        m_axis_tlast   // last
);

    localparam int ADDR_W = $clog2(DIM*DIM);
    localparam int CNT_W  = $clog2(DIM);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         k_reg, k_next;
    logic [CNT_W-1:0]         j_reg, j_next;
    logic [ADDR_W-1:0]        a_addr_reg, a_addr_next;
    logic [ADDR_W-1:0]        b_addr_reg, b_addr_next;
    logic [ADDR_W-1:0]        base_reg, base_next;
    logic [IDX_W-1:0]         row_reg, row_next;

    logic                     adv;
    logic                     issue;
    logic                     k_last;
    logic                     j_last;
    logic                     we_a;
    logic                     we_b;
    logic signed [DATA_W-1:0] a_rdata;
    logic signed [DATA_W-1:0] b_rdata;

    logic                     s1_valid_reg;
    logic                     s1_first_reg;
    logic                     s1_last_reg;
    logic [IDX_W-1:0]         s1_col_reg;
    logic [IDX_W-1:0]         s1_row_reg;

    logic                     s2_valid_reg;
    logic                     s2_first_reg;
    logic                     s2_last_reg;
    logic [IDX_W-1:0]         s2_col_reg;
    logic [IDX_W-1:0]         s2_row_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;

    logic signed [SUM_W-1:0]  acc_reg;
    logic signed [SUM_W-1:0]  sum_now;

    logic                     out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]         out_row_reg;
    logic [IDX_W-1:0]         out_col_reg;
    logic signed [SUM_W-1:0]  out_sum_reg;
    logic                     out_last_reg;

    // whole pipeline holds while a result waits on the output
    assign adv    = !out_valid_reg || m_axis_tready;
    assign issue  = adv && (state_reg == ST_RUN);
    assign k_last = k_reg == CNT_W'(DIM-1);
    assign j_last = j_reg == CNT_W'(DIM-1);
    assign pop    = adv && (state_reg == ST_IDLE) && !q_empty;
    assign we_a   = pop && (q_cmd.cmd == CMD_LOAD_A);
    assign we_b   = pop && (q_cmd.cmd == CMD_LOAD_B);

    smm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DIM*DIM)
    ) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (q_addr),
        .wdata (q_cmd.value),
        .re    (issue),
        .raddr (a_addr_reg),
        .rdata (a_rdata)
    );

    smm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DIM*DIM)
    ) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (q_addr),
        .wdata (q_cmd.value),
        .re    (issue),
        .raddr (b_addr_reg),
        .rdata (b_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        j_next      = j_reg;
        a_addr_next = a_addr_reg;
        b_addr_next = b_addr_reg;
        base_next   = base_reg;
        row_next    = row_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop && (q_cmd.cmd == CMD_COMPUTE))
                begin
                    state_next  = ST_RUN;
                    k_next      = '0;
                    j_next      = '0;
                    base_next   = q_addr;
                    a_addr_next = q_addr;
                    b_addr_next = '0;
                    row_next    = q_cmd.row;
                end
            end
            ST_RUN:
            begin
                if (adv)
                begin
                    if (k_last)
                    begin
                        k_next      = '0;
                        j_next      = j_reg + 1'b1;
                        a_addr_next = base_reg;
                        b_addr_next = ADDR_W'(j_next);
                        if (j_last)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        k_next      = k_reg + 1'b1;
                        a_addr_next = a_addr_reg + 1'b1;
                        b_addr_next = b_addr_reg + ADDR_W'(DIM);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign prod_next = a_rdata * b_rdata;
    assign sum_now   = (s2_first_reg ? '0 : acc_reg)
                     + {{(SUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = s2_valid_reg && s2_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                s1_valid_reg <= issue;
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        j_reg      <= j_next;
        a_addr_reg <= a_addr_next;
        b_addr_reg <= b_addr_next;
        base_reg   <= base_next;
        row_reg    <= row_next;
        if (adv)
        begin
            s1_first_reg <= k_reg == '0;
            s1_last_reg  <= k_last;
            s1_col_reg   <= IDX_W'(j_reg);
            s1_row_reg   <= row_reg;
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            s2_col_reg   <= s1_col_reg;
            s2_row_reg   <= s1_row_reg;
            prod_reg     <= prod_next;
            if (s2_valid_reg)
            begin
                acc_reg <= sum_now;
            end
            if (s2_valid_reg && s2_last_reg)
            begin
                out_row_reg  <= s2_row_reg;
                out_col_reg  <= s2_col_reg;
                out_sum_reg  <= sum_now;
                out_last_reg <= s2_col_reg == IDX_W'(DIM-1);
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_sum_reg, out_col_reg, out_row_reg};
    assign m_axis_tlast  = out_last_reg;

    `SMM_NEVER(a_pop_while_run, clk, rst_n, pop && (state_reg == ST_RUN))
    `SMM_NEVER(a_first_and_last, clk, rst_n, s2_valid_reg && s2_first_reg && s2_last_reg)
    `SMM_ASSERT(a_issue_to_s1, clk, rst_n, issue |=> s1_valid_reg)
    `SMM_ASSERT(a_last_col, clk, rst_n,
        (out_valid_reg && out_last_reg) |-> (out_col_reg == IDX_W'(DIM-1)))
    `SMM_ASSERT(a_hold_on_stall, clk, rst_n,
        (out_valid_reg && !m_axis_tready) |=> $stable(s2_valid_reg) && $stable(prod_reg))

endmodule

// ===== rtl/square_matrix_multiply.sv =====
`timescale 1ns / 1ps
// Channel   Dir   Payload                                           Handshake
// s_axis    in    tdata: row, col, value; tuser: cmd                tvalid/tready
// m_axis    out   tdata: out_row, out_col, sum; tlast: last         tvalid/tready
//
// A load takes only its pop in the back end; a compute row holds it for the pop, then
// one MAC per cycle while no result stalls (set by the single read port of each element
// store); the final column then passes the read, product and output registers.
// Input is taken every cycle while the command queue has room.
// Reset clears control only; element stores hold garbage until loaded.
// An unaccepted result freezes the MAC pipeline; the front keeps filling the queue.

module square_matrix_multiply
    import smm_pkg::*;
#(
    parameter int DIM = SMM_DIM
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // row[5:0], col[11:6], value[27:12]
    input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // out_row[5:0], out_col[11:6], sum[51:12]
    output logic        m_axis_tlast    // last
);

    localparam int ADDR_W = $clog2(DIM*DIM);
    localparam int Q_W    = $bits(smm_cmd_t) + ADDR_W;

    logic              push;
    smm_cmd_t          push_cmd;
    logic [ADDR_W-1:0] push_addr;
    logic              q_full;
    logic              q_empty;
    logic              pop;
    logic [Q_W-1:0]    q_dout;
    smm_cmd_t          q_cmd;
    logic [ADDR_W-1:0] q_addr;

    smm_front #(
        .DIM (DIM)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .push          (push),
        .push_cmd      (push_cmd),
        .push_addr     (push_addr)
    );

    smm_queue #(
        .WIDTH (Q_W),
        .DEPTH (SMM_QDEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   ({push_addr, push_cmd}),
        .full  (q_full),
        .pop   (pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    assign q_cmd  = q_dout[$bits(smm_cmd_t)-1:0];
    assign q_addr = q_dout[Q_W-1:$bits(smm_cmd_t)];

    smm_back #(
        .DIM (DIM)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_cmd         (q_cmd),
        .q_addr        (q_addr),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== tb/tb_square_matrix_multiply.sv =====
`timescale 1ns / 1ps

module tb_square_matrix_multiply;
    import smm_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 3000;
    localparam int RANDOM_ITEMS = 140;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } rx_mode_t;

    typedef struct {
        logic [IDX_W-1:0]        out_row;
        logic [IDX_W-1:0]        out_col;
        logic signed [SUM_W-1:0] sum;
        logic                    last;
    } c_elem_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // row[5:0], col[11:6], value[27:12]
    logic [1:0]  s_axis_tuser = '0;   // cmd[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;        // out_row[5:0], out_col[11:6], sum[51:12]
    logic        m_axis_tlast;

    logic signed [DATA_W-1:0] mat_a [SMM_DIM][SMM_DIM];
    logic signed [DATA_W-1:0] mat_b [SMM_DIM][SMM_DIM];
    c_elem_t c_row_q[$];

    int err_count = 0;
    int n_loads = 0;
    int n_computes = 0;
    int n_ignored = 0;
    int n_results = 0;

    int burst_left = 0;
    bit tx_gaps_on = 1'b1;

    int       rx_hold_cycles = 0;
    rx_mode_t rx_mode = RX_ALWAYS;
    int       rx_phase_cnt = 0;
    int       rx_phase_len = 200;
    int       rx_tick = 0;

    square_matrix_multiply i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 clk = ~clk;

    task automatic report_mismatch(input string what, input longint exp_v,
                                   input longint got_v);
        err_count++;
        $display("[%0t] MISMATCH %s: expected %0d, got %0d",
                 $realtime, what, exp_v, got_v);
    endtask

    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return 16'h0001;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // One input transaction; store updates and row sums are predicted on acceptance.
    task automatic send_txn(input logic [1:0] cmd, input logic [IDX_W-1:0] row,
                            input logic [IDX_W-1:0] col, input logic [DATA_W-1:0] value);
        int      gap;
        longint  acc;
        c_elem_t e;
        if (tx_gaps_on && burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                     : $urandom_range(1, 10);
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, value, col, row};
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        case (cmd)
            CMD_LOAD_A:
            begin
                mat_a[row][col] = value;
                n_loads++;
            end
            CMD_LOAD_B:
            begin
                mat_b[row][col] = value;
                n_loads++;
            end
            CMD_COMPUTE:
            begin
                n_computes++;
                for (int j = 0; j < SMM_DIM; j++)
                begin
                    acc = 0;
                    for (int k = 0; k < SMM_DIM; k++)
                        acc += longint'(mat_a[row][k]) * longint'(mat_b[k][j]);
                    e.out_row = row;
                    e.out_col = j[IDX_W-1:0];
                    e.sum     = acc[SUM_W-1:0];
                    e.last    = (j == SMM_DIM - 1);
                    c_row_q.push_back(e);
                end
            end
            default: n_ignored++;
        endcase
    endtask

    task automatic sender_stop();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic wait_drained();
        sender_stop();
        while (c_row_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // Every entry of both stores is written before any compute reads it.
    // A row 0 and B column 0 are full-scale negative, A row 63 and B column 63
    // full-scale positive.
    task automatic test_fill_stores();
        tx_gaps_on = 1'b0;
        for (int r = 0; r < SMM_DIM; r++)
            for (int c = 0; c < SMM_DIM; c++)
                send_txn(CMD_LOAD_A, r[IDX_W-1:0], c[IDX_W-1:0],
                         (r == 0) ? 16'h8000 : (r == SMM_DIM - 1) ? 16'h7FFF : rand_value());
        tx_gaps_on = 1'b1;
        for (int r = 0; r < SMM_DIM; r++)
            for (int c = 0; c < SMM_DIM; c++)
                send_txn(CMD_LOAD_B, r[IDX_W-1:0], c[IDX_W-1:0],
                         (c == 0) ? 16'h8000 : (c == SMM_DIM - 1) ? 16'h7FFF : rand_value());
        sender_stop();
    endtask

    // Row 0 x column 0 reaches +2^36; the mixed-sign corners reach the negative peak.
    task automatic test_extreme_rows();
        send_txn(CMD_COMPUTE, 6'd0, 6'd63, 16'hFFFF);
        send_txn(CMD_COMPUTE, 6'd63, 6'd0, 16'h0000);
        send_txn(CMD_COMPUTE, 6'd42, 6'd21, 16'h5555);
        sender_stop();
    endtask

    task automatic test_unused_cmd();
        send_txn(CMD_UNUSED, 6'd0, 6'd0, 16'h7FFF);
        send_txn(CMD_UNUSED, 6'd63, 6'd63, 16'h0000);
        send_txn(CMD_UNUSED, 6'd0, 6'd63, 16'h8000);
        send_txn(CMD_UNUSED, IDX_W'($urandom), IDX_W'($urandom), rand_value());
        send_txn(CMD_COMPUTE, 6'd0, 6'd0, 16'h0000);
        sender_stop();
    endtask

    // Loads queued behind a compute must not leak into that compute.
    task automatic test_load_compute_order();
        send_txn(CMD_LOAD_A, 6'd1, 6'd0, 16'h7FFF);
        send_txn(CMD_COMPUTE, 6'd1, 6'd0, 16'h0000);
        send_txn(CMD_LOAD_A, 6'd1, 6'd0, 16'h8000);
        send_txn(CMD_LOAD_B, 6'd0, 6'd0, 16'h8000);
        send_txn(CMD_COMPUTE, 6'd1, 6'd0, 16'h0000);
        sender_stop();
    endtask

    task automatic test_backpressure();
        wait_drained();
        rx_hold_cycles = HOLD_CYCLES;
        tx_gaps_on = 1'b0;
        send_txn(CMD_COMPUTE, IDX_W'($urandom), 6'd0, 16'h0000);
        for (int i = 0; i < 10; i++)
            send_txn(($urandom_range(0, 1) == 0) ? CMD_LOAD_A : CMD_LOAD_B,
                     IDX_W'($urandom), IDX_W'($urandom), rand_value());
        send_txn(CMD_COMPUTE, IDX_W'($urandom), 6'd0, 16'h0000);
        tx_gaps_on = 1'b1;
        sender_stop();
    endtask

    task automatic test_random_traffic(input int n_items);
        int pick;
        for (int i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                send_txn(CMD_UNUSED, IDX_W'($urandom), IDX_W'($urandom), rand_value());
            else if (pick < 20)
                send_txn(CMD_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), rand_value());
            else if (pick < 60)
                send_txn(CMD_LOAD_A, IDX_W'($urandom), IDX_W'($urandom), rand_value());
            else
                send_txn(CMD_LOAD_B, IDX_W'($urandom), IDX_W'($urandom), rand_value());
        end
        sender_stop();
    endtask

    // Receiver: long hold-off when requested, otherwise a mode that changes over time.
    always @(negedge clk)
    begin
        rx_tick++;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (rx_hold_cycles > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_hold_cycles--;
        end
        else
        begin
            rx_phase_cnt++;
            if (rx_phase_cnt >= rx_phase_len)
            begin
                rx_phase_cnt = 0;
                rx_phase_len = $urandom_range(100, 800);
                rx_mode = rx_mode_t'($urandom_range(0, 2));
            end
            case (rx_mode)
                RX_ALWAYS: m_axis_tready <= 1'b1;
                RX_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default:   m_axis_tready <= ((rx_tick % 7) < 4);
            endcase
        end
    end

    always @(posedge clk)
    begin : result_check
        c_elem_t exp_e;
        longint  got_sum;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_results++;
            got_sum = $signed(m_axis_tdata[51:12]);
            if (c_row_q.size() == 0)
                report_mismatch("transaction with nothing expected, sum", 0, got_sum);
            else
            begin
                exp_e = c_row_q.pop_front();
                if (m_axis_tdata[5:0] !== exp_e.out_row)
                    report_mismatch("out_row", exp_e.out_row, m_axis_tdata[5:0]);
                if (m_axis_tdata[11:6] !== exp_e.out_col)
                    report_mismatch("out_col", exp_e.out_col, m_axis_tdata[11:6]);
                if (m_axis_tdata[51:12] !== exp_e.sum)
                    report_mismatch("sum", exp_e.sum, got_sum);
                if (m_axis_tlast !== exp_e.last)
                    report_mismatch("last", exp_e.last, m_axis_tlast);
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_fill_stores();
        test_extreme_rows();
        test_unused_cmd();
        test_load_compute_order();
        test_backpressure();
        test_random_traffic(RANDOM_ITEMS);
        wait_drained();

        $display("Run covered %0d element loads, %0d row computes, %0d unused commands,",
                 n_loads, n_computes, n_ignored);
        $display("%0d results checked, full-scale operands and a %0d-cycle output hold-off.",
                 n_results, HOLD_CYCLES);
        if (err_count == 0)
            $display("** square_matrix_multiply: PASSED **");
        else
            $display("** square_matrix_multiply: FAILED **");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Timeout with %0d results still expected", c_row_q.size());
        $display("** square_matrix_multiply: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/smm_pkg.sv
rtl/smm_ram.sv
rtl/smm_front.sv
rtl/smm_queue.sv
rtl/smm_back.sv
rtl/square_matrix_multiply.sv
tb/tb_square_matrix_multiply.sv
